[rtl/core/mste_pkg.sv]
// Shared types and constants for the magnetic stripe F2F track encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package mste_pkg;

  localparam int unsigned MAX_PAD_BITS = 25;
  localparam int unsigned ADDR_W       = 4;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // Register map, index = paddr[3:2]
  localparam logic [1:0] REG_DATA_BITS   = 2'd0;
  localparam logic [1:0] REG_CHAR_OFFSET = 2'd1;
  localparam logic [1:0] REG_PAD_BITS    = 2'd2;

  localparam logic [2:0] DATA_BITS_RST   = 3'd6;
  localparam logic [6:0] CHAR_OFFSET_RST = 7'd32;
  localparam logic [4:0] PAD_BITS_RST    = 5'd25;

  typedef struct packed {
    logic [2:0] data_bits;
    logic [6:0] char_offset;
    logic [4:0] pad_bits;
  } cfg_t;

  // One classified character, ready for the serialiser
  typedef struct packed {
    logic [5:0] value;   // data bits of the character
    logic [5:0] lrc;     // LRC character, valid when fin is set
    logic [2:0] nbits;   // clamped data bit count, 4..6
    logic [4:0] pad;     // clamped padding length
    logic       lead;    // first character of a track: leading padding
    logic       fin;     // last character: LRC and trailing padding
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAD,
    ST_DATA,
    ST_PAR,
    ST_LDATA,
    ST_LPAR,
    ST_TRAIL
  } cell_state_t;

  function automatic logic sel_bit(input logic [5:0] v, input logic [2:0] idx);
    logic b;
    case (idx)
      3'd0:    b = v[0];
      3'd1:    b = v[1];
      3'd2:    b = v[2];
      3'd3:    b = v[3];
      3'd4:    b = v[4];
      3'd5:    b = v[5];
      default: b = 1'b0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/core/mste_front.sv]
// Front end: accepts characters, applies offset and clamps, tracks LRC.
// Depends on mste_pkg; feeds mste_cmdq.
`default_nettype none

module mste_front
  import mste_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg_i,
  input  wire logic       accept_i,
  input  wire logic [6:0] char_code_i,
  input  wire logic       final_char_i,
  output cmd_t            cmd_o
);

  logic [5:0] lrc_r, lrc_nxt;
  logic       started_r, started_nxt;
  logic [2:0] nbits;
  logic [4:0] pad;
  logic [5:0] mask;
  logic [6:0] diff;
  logic [5:0] value;

  always_comb begin
    if (cfg_i.data_bits < 3'd4) begin
      nbits = 3'd4;
    end else if (cfg_i.data_bits > 3'd6) begin
      nbits = 3'd6;
    end else begin
      nbits = cfg_i.data_bits;
    end
    pad = (cfg_i.pad_bits > 5'(MAX_PAD_BITS)) ? 5'(MAX_PAD_BITS) : cfg_i.pad_bits;
    case (nbits)
      3'd4:    mask = 6'h0f;
      3'd5:    mask = 6'h1f;
      default: mask = 6'h3f;
    endcase
    diff  = char_code_i - cfg_i.char_offset;
    value = diff[5:0] & mask;
    // a new track starts the LRC from zero
    lrc_nxt     = (started_r ? lrc_r : 6'd0) ^ value;
    started_nxt = ~final_char_i;

    cmd_o.value = value;
    cmd_o.lrc   = lrc_nxt & mask;
    cmd_o.nbits = nbits;
    cmd_o.pad   = pad;
    cmd_o.lead  = ~started_r;
    cmd_o.fin   = final_char_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lrc_r     <= 6'd0;
      started_r <= 1'b0;
    end else if (accept_i) begin
      lrc_r     <= lrc_nxt;
      started_r <= started_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/mste_cmdq.sv]
// Two-entry command queue between front end and cell serialiser.
// Depends on mste_pkg.
`default_nettype none

module mste_cmdq
  import mste_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  cmd_t       entry_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full_o  = (count_r == 2'(QUEUE_DEPTH));
  assign valid_o = (count_r != 2'd0);
  assign cmd_o   = entry_r[rd_ptr_r];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= cmd_i;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(QUEUE_DEPTH))
    else $error("command queue over-filled");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("push into full command queue");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + 2'd1)
    else $error("command queue count did not advance");

endmodule

`default_nettype wire

[rtl/core/mste_back.sv]
// Back end: turns queued commands into F2F bit cells, one cell per cycle
// while pop_i is high, into a single output register. Depends on mste_pkg.
`default_nettype none

module mste_back
  import mste_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid_i,
  input  wire cmd_t q_cmd_i,
  output logic      q_pop_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output logic      first_half_o,
  output logic      second_half_o,
  output logic      end_of_run_o
);

  cell_state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic        coil_r, coil_nxt;
  logic        par_r, par_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_first_r, out_first_nxt;
  logic        out_second_r, out_second_nxt;
  logic        out_end_r, out_end_nxt;

  logic       adv, emit, load, last, bit_val, first, second;
  logic [4:0] nb_last;

  assign nb_last = 5'(cmd_r.nbits) - 5'd1;

  // Output / datapath logic
  always_comb begin
    adv  = ~out_valid_r | pop_i;
    emit = (state_r != ST_IDLE) & adv;
    case (state_r)
      ST_DATA:  bit_val = sel_bit(cmd_r.value, cnt_r[2:0]);
      ST_LDATA: bit_val = sel_bit(cmd_r.lrc, cnt_r[2:0]);
      ST_PAR:   bit_val = par_r;
      ST_LPAR:  bit_val = par_r;
      default:  bit_val = 1'b0;
    endcase
    case (state_r)
      ST_PAR:   last = ~cmd_r.fin;
      ST_LPAR:  last = (cmd_r.pad == 5'd0);
      ST_TRAIL: last = (cnt_r == 5'd0);
      default:  last = 1'b0;
    endcase
    load    = q_valid_i & ((state_r == ST_IDLE) | (emit & last));
    q_pop_o = load;
    first   = ~coil_r;
    second  = first ^ bit_val;

    coil_nxt = coil_r;
    if (load && q_cmd_i.lead) begin
      coil_nxt = 1'b0;
    end else if (emit) begin
      coil_nxt = second;
    end

    par_nxt = par_r;
    if (load) begin
      par_nxt = 1'b1;
    end else if (emit) begin
      case (state_r)
        ST_DATA:  par_nxt = par_r ^ bit_val;
        ST_LDATA: par_nxt = par_r ^ bit_val;
        ST_PAR:   par_nxt = 1'b1;
        default:  par_nxt = par_r;
      endcase
    end

    out_valid_nxt  = emit | (out_valid_r & ~pop_i);
    out_first_nxt  = emit ? first : out_first_r;
    out_second_nxt = emit ? second : out_second_r;
    out_end_nxt    = emit ? last : out_end_r;
  end

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    if (emit) begin
      case (state_r)
        ST_LEAD: begin
          if (cnt_r == 5'd0) begin
            state_nxt = ST_DATA;
          end else begin
            cnt_nxt = cnt_r - 5'd1;
          end
        end
        ST_DATA: begin
          if (cnt_r == nb_last) begin
            state_nxt = ST_PAR;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
        ST_PAR: begin
          cnt_nxt   = 5'd0;
          state_nxt = cmd_r.fin ? ST_LDATA : ST_IDLE;
        end
        ST_LDATA: begin
          if (cnt_r == nb_last) begin
            state_nxt = ST_LPAR;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
        ST_LPAR: begin
          cnt_nxt   = cmd_r.pad - 5'd1;
          state_nxt = (cmd_r.pad != 5'd0) ? ST_TRAIL : ST_IDLE;
        end
        ST_TRAIL: begin
          if (cnt_r == 5'd0) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r - 5'd1;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
    if (load) begin
      cmd_nxt = q_cmd_i;
      if (q_cmd_i.lead && (q_cmd_i.pad != 5'd0)) begin
        state_nxt = ST_LEAD;
        cnt_nxt   = q_cmd_i.pad - 5'd1;
      end else begin
        state_nxt = ST_DATA;
        cnt_nxt   = 5'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 5'd0;
      coil_r      <= 1'b0;
      par_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      coil_r      <= coil_nxt;
      par_r       <= par_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_end_r    <= out_end_nxt;
  end

  assign empty_o       = ~out_valid_r;
  assign first_half_o  = out_first_r;
  assign second_half_o = out_second_r;
  assign end_of_run_o  = out_end_r;

  a_data_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA || state_r == ST_LDATA) |-> cnt_r <= nb_last)
    else $error("data bit index beyond character width");

  a_idle_pickup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && q_valid_i) |=> state_r != ST_IDLE)
    else $error("queued command not picked up");

  a_lead_coil: assert property (@(posedge clk) disable iff (!rst_n)
    (load && q_cmd_i.lead) |=> coil_r == 1'b0)
    else $error("coil level not cleared at track start");

endmodule

`default_nettype wire

[rtl/core/magstripe_track_f2f_encoder_unit.sv]
// Magnetic stripe track F2F encoder, top level: APB registers and the
// front end / command queue / cell serialiser chain. Depends on mste_pkg.
//
// Usage: push one track character (char_code, final_char) per transaction
// while full is low. Each character yields its F2F bit cells on the result
// side, one transaction per cell while empty is low; end_of_run marks the
// last cell of a character. The first character of a track is preceded by
// pad_bits zero cells; the final one is followed by the LRC character and
// pad_bits zero cells; pad_bits is clamped to 25.
// The first cell of a character passes through the command queue and the
// serialiser state into the output register. Throughput: one cell per
// cycle while pop is high; a character has data_bits+1 cells (5 to 7),
// more with padding and LRC; the two-entry queue lets the input run ahead.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// queue, the output register and the track state.
// A stalled receiver (pop low) holds the current cell; the serialiser and
// then the queue fill, after which full is raised.
// Registers at byte addresses 0, 4, 8: data_bits, char_offset, pad_bits;
// write only while the block is idle.
`default_nettype none

module magstripe_track_f2f_encoder_unit
  import mste_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [6:0]        in_char_code,
  input  wire logic              in_final_char,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   out_first_half_level,
  output logic                   out_second_half_level,
  output logic                   out_end_of_run
);

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;
  logic       accept;
  cmd_t       front_cmd, q_cmd;
  logic       q_full, q_valid, q_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_DATA_BITS:   cfg_nxt.data_bits   = pwdata[2:0];
        REG_CHAR_OFFSET: cfg_nxt.char_offset = pwdata[6:0];
        REG_PAD_BITS:    cfg_nxt.pad_bits    = pwdata[4:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DATA_BITS:   prdata = {29'd0, cfg_r.data_bits};
      REG_CHAR_OFFSET: prdata = {25'd0, cfg_r.char_offset};
      REG_PAD_BITS:    prdata = {27'd0, cfg_r.pad_bits};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_bits   <= DATA_BITS_RST;
      cfg_r.char_offset <= CHAR_OFFSET_RST;
      cfg_r.pad_bits    <= PAD_BITS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign full   = q_full;
  assign accept = push & ~q_full;

  mste_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg_r),
    .accept_i     (accept),
    .char_code_i  (in_char_code),
    .final_char_i (in_final_char),
    .cmd_o        (front_cmd)
  );

  mste_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  mste_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .q_pop_o       (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .first_half_o  (out_first_half_level),
    .second_half_o (out_second_half_level),
    .end_of_run_o  (out_end_of_run)
  );

endmodule

`default_nettype wire

[dv/tb_magstripe_track_f2f_encoder_unit.sv]
// Self-checking testbench for the magnetic stripe F2F track encoder.
// Drives track characters and APB register writes, predicts every bit cell
// and checks the cells in order. Depends on mste_pkg and the encoder RTL.
`default_nettype none

module tb_magstripe_track_f2f_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mste_pkg::*;

  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned RANDOM_ITEMS = 290;

  typedef struct packed {
    logic [6:0] code;
    logic       fin;
  } track_char_t;

  typedef struct packed {
    logic first;
    logic second;
    logic eor;
  } cell_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              push = 1'b0;
  logic              full;
  logic [6:0]        in_char_code = '0;
  logic              in_final_char = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic              out_first_half_level;
  logic              out_second_half_level;
  logic              out_end_of_run;

  magstripe_track_f2f_encoder_unit u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .push                 (push),
    .full                 (full),
    .in_char_code         (in_char_code),
    .in_final_char        (in_final_char),
    .empty                (empty),
    .pop                  (pop),
    .out_first_half_level (out_first_half_level),
    .out_second_half_level(out_second_half_level),
    .out_end_of_run       (out_end_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stimulus and expected cells
  track_char_t chars_pending[$];
  cell_t       cells_due[$];
  int unsigned n_issued = 0;
  int unsigned n_taken = 0;
  int unsigned n_errors = 0;
  int unsigned stall_cycles = 0;
  int unsigned in_idle_max = 9;
  int unsigned out_idle_max = 9;
  bit          in_acc = 1'b0;
  bit          out_acc = 1'b0;

  // Predictor state and register copies
  logic       coil_lvl = 1'b0;
  logic [5:0] lrc_acc = '0;
  logic       in_track = 1'b0;
  logic [2:0] r_data_bits = DATA_BITS_RST;
  logic [6:0] r_char_offset = CHAR_OFFSET_RST;
  logic [4:0] r_pad_bits = PAD_BITS_RST;

  function automatic void add_cell(input logic b);
    cell_t c;
    coil_lvl = ~coil_lvl;
    c.first = coil_lvl;
    if (b) coil_lvl = ~coil_lvl;
    c.second = coil_lvl;
    c.eor = 1'b0;
    cells_due.push_back(c);
  endfunction

  // data bits LSB first, then odd parity
  function automatic void add_char(input logic [5:0] val, input int unsigned nb);
    logic par;
    par = 1'b1;
    for (int j = 0; j < nb; j++) begin
      par = par ^ val[j];
      add_cell(val[j]);
    end
    add_cell(par);
  endfunction

  function automatic void encode_char(input logic [6:0] code, input logic fin);
    int unsigned nb;
    int unsigned pad;
    logic [6:0] diff;
    logic [5:0] mask;
    logic [5:0] val;
    cell_t c;
    nb = r_data_bits;
    if (nb < 4) nb = 4;
    if (nb > 6) nb = 6;
    pad = r_pad_bits;
    if (pad > MAX_PAD_BITS) pad = MAX_PAD_BITS;
    mask = 6'h3f >> (6 - nb);
    if (!in_track) begin
      coil_lvl = 1'b0;
      lrc_acc = '0;
      in_track = 1'b1;
      for (int i = 0; i < pad; i++) add_cell(1'b0);
    end
    diff = code - r_char_offset;
    val = diff[5:0] & mask;
    lrc_acc = lrc_acc ^ val;
    add_char(val, nb);
    if (fin) begin
      add_char(lrc_acc & mask, nb);
      for (int i = 0; i < pad; i++) add_cell(1'b0);
      in_track = 1'b0;
    end
    c = cells_due.pop_back();
    c.eor = 1'b1;
    cells_due.push_back(c);
  endfunction

  // Monitor: transactions on both sides, checking and watchdog
  always @(posedge clk) begin : mon_p
    cell_t exp_c;
    in_acc = rst_n && push && !full;
    out_acc = rst_n && pop && !empty;
    if (in_acc) begin
      encode_char(in_char_code, in_final_char);
      n_taken++;
    end
    if (out_acc) begin
      if (cells_due.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected cell first=%0b second=%0b eor=%0b", $time,
                 out_first_half_level, out_second_half_level, out_end_of_run);
      end else begin
        exp_c = cells_due.pop_front();
        if (out_first_half_level !== exp_c.first) begin
          n_errors++;
          $display("%0t: first_half_level expected %0b actual %0b", $time,
                   exp_c.first, out_first_half_level);
        end
        if (out_second_half_level !== exp_c.second) begin
          n_errors++;
          $display("%0t: second_half_level expected %0b actual %0b", $time,
                   exp_c.second, out_second_half_level);
        end
        if (out_end_of_run !== exp_c.eor) begin
          n_errors++;
          $display("%0t: end_of_run expected %0b actual %0b", $time,
                   exp_c.eor, out_end_of_run);
        end
      end
    end
    if (in_acc || out_acc) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Input driver
  always @(negedge clk) begin : drv_in
    int unsigned gap;
    track_char_t ch;
    if (rst_n) begin
      if (push && !in_acc) begin
        // transaction still offered
      end else if (gap > 0) begin
        gap--;
        push <= 1'b0;
      end else if (chars_pending.size() > 0) begin
        ch = chars_pending.pop_front();
        in_char_code <= ch.code;
        in_final_char <= ch.fin;
        push <= 1'b1;
        gap = $urandom_range(0, in_idle_max);
      end else begin
        push <= 1'b0;
      end
    end else begin
      gap = 0;
    end
  end

  // Result receiver
  always @(negedge clk) begin : drv_out
    int unsigned gap;
    if (rst_n) begin
      if (out_acc) gap = $urandom_range(0, out_idle_max);
      if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end else begin
      gap = 0;
    end
  end

  task automatic queue_char(input logic [6:0] code, input logic fin);
    track_char_t ch;
    ch.code = code;
    ch.fin = fin;
    chars_pending.push_back(ch);
    n_issued++;
  endtask

  task automatic wait_drained();
    while (n_taken != n_issued || cells_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DATA_BITS:   r_data_bits = data[2:0];
      REG_CHAR_OFFSET: r_char_offset = data[6:0];
      REG_PAD_BITS:    r_pad_bits = data[4:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(input logic [2:0] db, input logic [6:0] off, input logic [4:0] pad);
    wait_drained();
    apb_write(REG_DATA_BITS, {29'd0, db});
    apb_write(REG_CHAR_OFFSET, {25'd0, off});
    apb_write(REG_PAD_BITS, {27'd0, pad});
  endtask

  function automatic logic [31:0] pick_field(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  initial begin : stim
    int unsigned plen;
    int unsigned k;
    int unsigned tlen;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: offset hits zero and all-ones values, two tracks
    queue_char(7'd32, 1'b0);
    queue_char(7'd127, 1'b0);
    queue_char(7'd0, 1'b0);
    queue_char(7'd95, 1'b1);
    queue_char(7'd65, 1'b1);

    // narrowest characters, no padding
    set_cfg(3'd4, 7'd0, 5'd0);
    queue_char(7'd0, 1'b1);
    queue_char(7'd127, 1'b0);
    queue_char(7'd15, 1'b1);

    // data_bits below range and padding above range are clamped
    set_cfg(3'd0, 7'd127, 5'd31);
    queue_char(7'd126, 1'b0);
    queue_char(7'd127, 1'b1);

    // data_bits above range; track left open across the next write
    set_cfg(3'd7, 7'd1, 5'd26);
    queue_char(7'd0, 1'b0);
    queue_char(7'd64, 1'b0);

    // LRC cut to the narrower width, wide accumulator from the open track
    set_cfg(3'd4, 7'd1, 5'd3);
    queue_char(7'd2, 1'b1);

    in_idle_max = 0;
    out_idle_max = 0;
    set_cfg(3'd5, 7'd32, 5'd1);
    queue_char(7'd33, 1'b0);
    queue_char(7'd100, 1'b0);
    queue_char(7'd7, 1'b1);

    k = 0;
    while (k < RANDOM_ITEMS) begin
      set_cfg(3'(pick_field(0, 7)), 7'(pick_field(0, 127)), 5'(pick_field(0, 31)));
      in_idle_max = ($urandom_range(0, 9) < 7) ? 9 : 0;
      out_idle_max = ($urandom_range(0, 9) < 7) ? 9 : 0;
      plen = $urandom_range(20, 60);
      for (int p = 0; p < plen; ) begin
        if ($urandom_range(0, 99) < 85) begin
          tlen = $urandom_range(1, 8);
          for (int j = 0; j < tlen; j++) begin
            queue_char(7'($urandom_range(0, 127)), j == tlen - 1);
          end
          p += tlen;
        end else begin
          queue_char(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
          p++;
        end
      end
      k += plen;
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
